// ----- rtl/lmc_pkg.sv -----
package lmc_pkg;

    localparam int LETTER_W         = 8;
    localparam int NUM_BINS         = 1 << LETTER_W;
    localparam int MAX_WORD_LEN_DEF = 64;

    localparam logic [1:0] REQ_BASE  = 2'd0;
    localparam logic [1:0] REQ_QUERY = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [LETTER_W-1:0] letter;
        logic                last;
    } t_in_item;

    typedef struct packed {
        logic                contained;
        logic                found;
        logic [LETTER_W-1:0] diff_letter;
        logic                overflow;
    } t_out_item;

endpackage

// ----- rtl/lmc_hist_mem.sv -----
module lmc_hist_mem #(
    parameter int CNT_W = 7
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_clr,
    input  logic [lmc_pkg::LETTER_W-1:0] i_rd_addr,
    output logic [CNT_W-1:0]             o_rd_data,
    input  logic                         i_wr_en,
    input  logic [lmc_pkg::LETTER_W-1:0] i_wr_addr,
    input  logic [CNT_W-1:0]             i_wr_data
);

    logic [CNT_W-1:0]             r_mem [lmc_pkg::NUM_BINS];
    logic [lmc_pkg::NUM_BINS-1:0] r_vld;
    logic [CNT_W-1:0]             r_q;
    logic [lmc_pkg::LETTER_W-1:0] r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_q       <= r_mem[i_rd_addr];
        r_rd_addr <= i_rd_addr;
    end

    // Entries never written since the last clear read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_clr) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_vld[r_rd_addr] ? r_q : '0;

endmodule

// ----- rtl/letter_multiset_containment.sv -----
// Channel | Direction | Handshake                  | Payload
// in      | input     | i_in_valid / o_in_ready    | i_in_data  (lmc_pkg::t_in_item)
// out     | output    | o_out_valid / i_out_ready  | o_out_data (lmc_pkg::t_out_item)
//
// Base, clear and query letters are accepted back to back: a two-stage
// read-modify-write on the count memories with forwarding from the last write.
// A query letter with last set starts a sweep of all 256 bins, one per cycle
// through the memory read port; input is stalled until the
// result is loaded into the output register.
// Reset (synchronous, active low) clears all valid bits, so both histograms
// read as empty at once. A full output register holds the sweep in its final state.
module letter_multiset_containment #(
    parameter int MAX_WORD_LEN = lmc_pkg::MAX_WORD_LEN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  lmc_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output lmc_pkg::t_out_item o_out_data
);

    localparam int CNT_W = $clog2(MAX_WORD_LEN + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_WORD_LEN);

    localparam logic [1:0] ST_RUN   = 2'd0;
    localparam logic [1:0] ST_SWEEP = 2'd1;
    localparam logic [1:0] ST_LAST  = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    logic [1:0] r_state, n_state;

    // letter stage
    logic                         r_s1_vld;
    logic [1:0]                   r_s1_type;
    logic [lmc_pkg::LETTER_W-1:0] r_s1_letter;
    logic                         r_s1_last;

    logic                         r_fw_vld;
    logic                         r_fw_query;
    logic [lmc_pkg::LETTER_W-1:0] r_fw_addr;
    logic [CNT_W-1:0]             r_fw_data;

    logic r_ovf;

    // sweep
    logic [lmc_pkg::LETTER_W-1:0] r_sw_cnt;
    logic                         r_cmp_vld;
    logic [lmc_pkg::LETTER_W-1:0] r_cmp_addr;
    logic                         r_ok;
    logic                         r_hit;
    logic [lmc_pkg::LETTER_W-1:0] r_which;

    logic               r_out_vld;
    lmc_pkg::t_out_item r_out;

    logic                         in_acc;
    logic                         s1_add, s1_query, s1_clr, s1_end;
    logic [lmc_pkg::LETTER_W-1:0] rd_addr, sw_addr;
    logic [CNT_W-1:0]             base_q, query_q, cur, new_cnt;
    logic                         sat, wr_en, base_wr, query_wr, query_clr, out_load;

    assign s1_query = r_s1_vld && (r_s1_type == lmc_pkg::REQ_QUERY);
    assign s1_add   = r_s1_vld && ((r_s1_type == lmc_pkg::REQ_BASE) || s1_query);
    assign s1_clr   = r_s1_vld && (r_s1_type == lmc_pkg::REQ_CLEAR);
    assign s1_end   = s1_query && r_s1_last;

    assign o_in_ready = (r_state == ST_RUN) && !s1_end;
    assign in_acc     = i_in_valid && o_in_ready;

    // Signed-char order: bins 128..255 first, then 0..127.
    assign sw_addr = {~r_sw_cnt[lmc_pkg::LETTER_W-1], r_sw_cnt[lmc_pkg::LETTER_W-2:0]};
    assign rd_addr = (r_state == ST_SWEEP) ? sw_addr : i_in_data.letter;

    always_comb begin
        if (r_fw_vld && (r_fw_query == s1_query) && (r_fw_addr == r_s1_letter)) begin
            cur = r_fw_data;
        end else begin
            cur = s1_query ? query_q : base_q;
        end
    end

    assign sat      = (cur >= MAX_CNT);
    assign new_cnt  = cur + CNT_W'(1);
    assign wr_en    = s1_add && !sat;
    assign base_wr  = wr_en && !s1_query;
    assign query_wr = wr_en && s1_query;

    assign out_load  = (r_state == ST_OUT) && (!r_out_vld || i_out_ready);
    assign query_clr = out_load;

    lmc_hist_mem #(.CNT_W(CNT_W)) u_base (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (s1_clr),
        .i_rd_addr (rd_addr),
        .o_rd_data (base_q),
        .i_wr_en   (base_wr),
        .i_wr_addr (r_s1_letter),
        .i_wr_data (new_cnt)
    );

    lmc_hist_mem #(.CNT_W(CNT_W)) u_query (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (query_clr),
        .i_rd_addr (rd_addr),
        .o_rd_data (query_q),
        .i_wr_en   (query_wr),
        .i_wr_addr (r_s1_letter),
        .i_wr_data (new_cnt)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_RUN: begin
                if (s1_end) begin
                    n_state = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (r_sw_cnt == '1) begin
                    n_state = ST_LAST;
                end
            end
            ST_LAST: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (out_load) begin
                    n_state = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_RUN;
            r_s1_vld  <= 1'b0;
            r_fw_vld  <= 1'b0;
            r_ovf     <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_s1_vld  <= in_acc;
            r_fw_vld  <= wr_en;
            r_cmp_vld <= (r_state == ST_SWEEP);
            if (s1_clr) begin
                r_ovf <= 1'b0;
            end else if (s1_add && sat) begin
                r_ovf <= 1'b1;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_type   <= i_in_data.req_type;
            r_s1_letter <= i_in_data.letter;
            r_s1_last   <= i_in_data.last;
        end
        r_fw_query <= s1_query;
        r_fw_addr  <= r_s1_letter;
        r_fw_data  <= new_cnt;
        r_cmp_addr <= sw_addr;

        if (r_state == ST_SWEEP) begin
            r_sw_cnt <= r_sw_cnt + lmc_pkg::LETTER_W'(1);
        end else begin
            r_sw_cnt <= '0;
        end

        if (r_state == ST_RUN) begin
            r_ok    <= 1'b1;
            r_hit   <= 1'b0;
            r_which <= '0;
        end else if (r_cmp_vld) begin
            if (query_q > base_q) begin
                r_ok <= 1'b0;
            end
            // keep the first bin with a positive remainder
            if ((base_q > query_q) && !r_hit) begin
                r_hit   <= 1'b1;
                r_which <= r_cmp_addr;
            end
        end

        if (out_load) begin
            r_out.contained   <= r_ok;
            r_out.found       <= r_ok && r_hit;
            r_out.diff_letter <= r_ok ? r_which : '0;
            r_out.overflow    <= r_ovf;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_found_needs_contained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out_data.found || o_out_data.contained))
        else $error("found without containment");

    a_no_diff_without_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.found) |-> (o_out_data.diff_letter == '0))
        else $error("diff letter set without found");

    a_last_starts_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_RUN) && s1_end) |=> (r_state == ST_SWEEP))
        else $error("last query letter did not start the sweep");

    a_sweep_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_RUN) |-> (!r_s1_vld && !wr_en))
        else $error("letter update during sweep");

    a_result_from_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_OUT))
        else $error("result loaded outside the sweep end");
`endif

endmodule
